### hw/rtl/sh4_group_c_instruction_execute_top_assert.svh
// Assertion macros for the checker file of the group C execute block.
`ifndef SH4_GROUP_C_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH
`define SH4_GROUP_C_INSTRUCTION_EXECUTE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SH4C_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sh4c check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SH4C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sh4c check failed");

`endif

### hw/rtl/sh4c_pkg.sv
package sh4c_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_RETIRE = 2'd2
  } kind_t;

  // Opcode in instruction bits 11:8
  localparam logic [3:0] OP_MOVB_ST = 4'h0;
  localparam logic [3:0] OP_MOVW_ST = 4'h1;
  localparam logic [3:0] OP_MOVL_ST = 4'h2;
  localparam logic [3:0] OP_TRAPA   = 4'h3;
  localparam logic [3:0] OP_MOVB_LD = 4'h4;
  localparam logic [3:0] OP_MOVW_LD = 4'h5;
  localparam logic [3:0] OP_MOVL_LD = 4'h6;
  localparam logic [3:0] OP_MOVA    = 4'h7;
  localparam logic [3:0] OP_TST_IMM = 4'h8;
  localparam logic [3:0] OP_AND_IMM = 4'h9;
  localparam logic [3:0] OP_XOR_IMM = 4'hA;
  localparam logic [3:0] OP_OR_IMM  = 4'hB;
  localparam logic [3:0] OP_TST_B   = 4'hC;
  localparam logic [3:0] OP_AND_B   = 4'hD;
  localparam logic [3:0] OP_XOR_B   = 4'hE;
  localparam logic [3:0] OP_OR_B    = 4'hF;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;
  localparam logic [1:0] SIZE_LONG = 2'd2;

  localparam logic       FUNC_INSTR = 1'b0;
  localparam logic       FUNC_RDATA = 1'b1;

  // One classified item on its way from front to back. data carries the
  // write data of a write beat or the new R0 of a retire beat. two marks
  // a write that is followed by a bare retire carrying npc.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [1:0]  size;
    logic [31:0] data;
    logic        r0_write;
    logic        t_out;
    logic        t_write;
    logic [31:0] npc;
    logic        status;
    logic        two;
  } entry_t;

endpackage

### hw/rtl/sh4c_front.sv
module sh4c_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            func,
  input  logic [15:0]     instr,
  input  logic [31:0]     r0,
  input  logic [31:0]     gbr,
  input  logic [31:0]     pc,
  input  logic [31:0]     rdata,
  output logic            ent_valid,
  output sh4c_pkg::entry_t ent
);
  import sh4c_pkg::*;

  logic        waiting_r, waiting_nxt;
  logic [3:0]  pend_op_r, pend_op_nxt;
  logic [31:0] pend_addr_r, pend_addr_nxt;
  logic [7:0]  pend_imm_r, pend_imm_nxt;
  logic [31:0] pend_pc_r, pend_pc_nxt;

  logic [3:0]  op;
  logic [7:0]  imm;
  logic [31:0] imm_ext;
  logic [31:0] npc_new;
  logic [31:0] npc_pend;
  logic [31:0] addr_disp;
  logic [31:0] addr_r0;
  logic [31:0] mova_val;
  logic [31:0] st_data;
  logic [7:0]  rbyte;
  logic [7:0]  rmw_byte;

  assign op        = instr[11:8];
  assign imm       = instr[7:0];
  assign imm_ext   = {24'd0, imm};
  assign npc_new   = pc + 32'd2;
  assign npc_pend  = pend_pc_r + 32'd2;
  // Loads and stores share the scale in op bits 1:0
  assign addr_disp = gbr + (imm_ext << op[1:0]);
  assign addr_r0   = r0 + gbr;
  assign mova_val  = {pc[31:2], 2'b00} + {22'd0, imm, 2'b00} + 32'd4;
  assign rbyte     = rdata[7:0];

  always_comb begin
    case (op[1:0])
      SIZE_BYTE: st_data = {24'd0, r0[7:0]};
      SIZE_WORD: st_data = {16'd0, r0[15:0]};
      default:   st_data = r0;
    endcase
  end

  always_comb begin
    case (pend_op_r)
      OP_AND_B: rmw_byte = rbyte & pend_imm_r;
      OP_XOR_B: rmw_byte = rbyte ^ pend_imm_r;
      default:  rmw_byte = rbyte | pend_imm_r;
    endcase
  end

  always_comb begin
    ent           = '0;
    ent.kind      = KIND_RETIRE;
    ent_valid     = 1'b0;
    waiting_nxt   = waiting_r;
    pend_op_nxt   = pend_op_r;
    pend_addr_nxt = pend_addr_r;
    pend_imm_nxt  = pend_imm_r;
    pend_pc_nxt   = pend_pc_r;
    if (accept) begin
      if (func == FUNC_INSTR) begin
        ent_valid   = 1'b1;
        waiting_nxt = 1'b0;
        ent.npc     = npc_new;
        case (op)
          OP_MOVB_ST, OP_MOVW_ST, OP_MOVL_ST: begin
            ent.kind = KIND_WRITE;
            ent.addr = addr_disp;
            ent.size = op[1:0];
            ent.data = st_data;
            ent.two  = 1'b1;
          end
          OP_TRAPA: begin
            ent.status = (imm == 8'd0);
          end
          OP_MOVA: begin
            ent.data     = mova_val;
            ent.r0_write = 1'b1;
          end
          OP_TST_IMM: begin
            ent.t_out   = ((r0[7:0] & imm) == 8'd0);
            ent.t_write = 1'b1;
          end
          OP_AND_IMM: begin
            ent.data     = r0 & imm_ext;
            ent.r0_write = 1'b1;
          end
          OP_XOR_IMM: begin
            ent.data     = r0 ^ imm_ext;
            ent.r0_write = 1'b1;
          end
          OP_OR_IMM: begin
            ent.data     = r0 | imm_ext;
            ent.r0_write = 1'b1;
          end
          OP_MOVB_LD, OP_MOVW_LD, OP_MOVL_LD: begin
            ent.kind      = KIND_READ;
            ent.addr      = addr_disp;
            ent.size      = op[1:0];
            ent.npc       = '0;
            waiting_nxt   = 1'b1;
            pend_op_nxt   = op;
            pend_addr_nxt = addr_disp;
            pend_imm_nxt  = imm;
            pend_pc_nxt   = pc;
          end
          default: begin
            // tst.b and the byte read-modify-write forms at R0+GBR
            ent.kind      = KIND_READ;
            ent.addr      = addr_r0;
            ent.size      = SIZE_BYTE;
            ent.npc       = '0;
            waiting_nxt   = 1'b1;
            pend_op_nxt   = op;
            pend_addr_nxt = addr_r0;
            pend_imm_nxt  = imm;
            pend_pc_nxt   = pc;
          end
        endcase
      end else if (waiting_r) begin
        // Returning data finishes the pending instruction; drop it otherwise
        ent_valid   = 1'b1;
        waiting_nxt = 1'b0;
        ent.npc     = npc_pend;
        case (pend_op_r)
          OP_MOVB_LD: begin
            ent.data     = {{24{rbyte[7]}}, rbyte};
            ent.r0_write = 1'b1;
          end
          OP_MOVW_LD: begin
            ent.data     = {{16{rdata[15]}}, rdata[15:0]};
            ent.r0_write = 1'b1;
          end
          OP_MOVL_LD: begin
            ent.data     = rdata;
            ent.r0_write = 1'b1;
          end
          OP_TST_B: begin
            ent.t_out   = ((rbyte & pend_imm_r) == 8'd0);
            ent.t_write = 1'b1;
          end
          default: begin
            ent.kind = KIND_WRITE;
            ent.addr = pend_addr_r;
            ent.size = SIZE_BYTE;
            ent.data = {24'd0, rmw_byte};
            ent.two  = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r   <= 1'b0;
      pend_op_r   <= '0;
      pend_addr_r <= '0;
      pend_imm_r  <= '0;
      pend_pc_r   <= '0;
    end else begin
      waiting_r   <= waiting_nxt;
      pend_op_r   <= pend_op_nxt;
      pend_addr_r <= pend_addr_nxt;
      pend_imm_r  <= pend_imm_nxt;
      pend_pc_r   <= pend_pc_nxt;
    end
  end

endmodule

### hw/rtl/sh4c_queue.sv
module sh4c_queue #(
  parameter int DEPTH = sh4c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  sh4c_pkg::entry_t wr_data,
  output logic             full,
  input  logic             rd_en,
  output sh4c_pkg::entry_t rd_data,
  output logic             empty
);
  import sh4c_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hw/rtl/sh4c_back.sv
module sh4c_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  sh4c_pkg::entry_t q_data,
  output logic             q_rd,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_addr,
  output logic [1:0]       out_size,
  output logic [31:0]      out_wdata,
  output logic [31:0]      out_r0_out,
  output logic             out_r0_write,
  output logic             out_t_out,
  output logic             out_t_write,
  output logic [31:0]      out_next_pc,
  output logic             out_status,
  output logic             out_last
);
  import sh4c_pkg::*;

  entry_t cur_r, cur_nxt;
  logic   valid_r, valid_nxt;
  logic   phase_r, phase_nxt;
  logic   free;
  logic   first;

  // Free to load when idle, or when the final beat of the current entry leaves
  assign free  = !valid_r || (out_pop && !(cur_r.two && !phase_r));
  assign q_rd  = free && !q_empty;
  assign first = !phase_r;

  always_comb begin
    cur_nxt   = cur_r;
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (free) begin
      valid_nxt = !q_empty;
      phase_nxt = 1'b0;
      if (!q_empty) begin
        cur_nxt = q_data;
      end
    end else if (out_pop) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Second beat of a write is a bare retire carrying only next_pc
  always_comb begin
    out_empty    = !valid_r;
    out_kind     = first ? cur_r.kind : KIND_RETIRE;
    out_addr     = first ? cur_r.addr : '0;
    out_size     = first ? cur_r.size : '0;
    out_wdata    = (first && cur_r.kind == KIND_WRITE) ? cur_r.data : '0;
    out_r0_out   = (first && cur_r.kind == KIND_RETIRE) ? cur_r.data : '0;
    out_r0_write = first && cur_r.r0_write;
    out_t_out    = first && cur_r.t_out;
    out_t_write  = first && cur_r.t_write;
    out_next_pc  = (!first || cur_r.kind == KIND_RETIRE) ? cur_r.npc : '0;
    out_status   = first && cur_r.status;
    out_last     = !first || !cur_r.two;
  end

endmodule

### hw/rtl/sh4_group_c_instruction_execute_top.sv
// Path: an accepted item is written into the classify queue, then loaded
// into the output stage. Throughput: one item per cycle at in_ while in_full
// is low; stores and byte read-modify-writes give two beats, so the output
// port, at one beat per cycle while out_pop is held, sets the sustained rate.
// Reset: rst_n is synchronous, active low; it empties the queue and output stage
// and clears the pending-read state.
module sh4_group_c_instruction_execute_top #(
  parameter int QUEUE_DEPTH = sh4c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [15:0] in_instr,
  input  logic [31:0] in_r0,
  input  logic [31:0] in_gbr,
  input  logic [31:0] in_pc,
  input  logic        in_t_in,
  input  logic [31:0] in_rdata,
  // result channel
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_kind,
  output logic [31:0] out_addr,
  output logic [1:0]  out_size,
  output logic [31:0] out_wdata,
  output logic [31:0] out_r0_out,
  output logic        out_r0_write,
  output logic        out_t_out,
  output logic        out_t_write,
  output logic [31:0] out_next_pc,
  output logic        out_status,
  output logic        out_last
);
  import sh4c_pkg::*;

  logic   accept;
  logic   ent_valid;
  entry_t ent;
  logic   q_rd;
  logic   q_empty;
  entry_t q_data;

  // Take a beat whenever the classify queue has room. in_t_in feeds no
  // operation of this group; the T result comes from data and immediate alone.
  assign accept = in_push && !in_full;

  // Front: decode the beat, track the one outstanding read, build an entry.
  // Returning data with no read outstanding yields no entry.
  sh4c_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_func),
    .instr     (in_instr),
    .r0        (in_r0),
    .gbr       (in_gbr),
    .pc        (in_pc),
    .rdata     (in_rdata),
    .ent_valid (ent_valid),
    .ent       (ent)
  );

  // Decoupling queue: full backpressures the input side only.
  sh4c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ent_valid),
    .wr_data (ent),
    .full    (in_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  // Back: hold one entry and expand it into one or two result beats.
  sh4c_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_rd         (q_rd),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_kind     (out_kind),
    .out_addr     (out_addr),
    .out_size     (out_size),
    .out_wdata    (out_wdata),
    .out_r0_out   (out_r0_out),
    .out_r0_write (out_r0_write),
    .out_t_out    (out_t_out),
    .out_t_write  (out_t_write),
    .out_next_pc  (out_next_pc),
    .out_status   (out_status),
    .out_last     (out_last)
  );

endmodule

### hw/rtl/sh4c_checker.sv
`include "sh4_group_c_instruction_execute_top_assert.svh"

module sh4c_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [1:0]  out_kind,
  input logic [31:0] out_addr,
  input logic [31:0] out_next_pc,
  input logic        out_last
);
  import sh4c_pkg::*;

  // A stalled beat holds
  `SH4C_ASSERT_NEXT(a_hold, !out_empty && !out_pop, !out_empty && $stable(out_kind) && $stable(out_addr))

  // A store beat never ends an item
  `SH4C_ASSERT_NOW(a_write_not_last, !out_empty && out_kind == KIND_WRITE, !out_last)

  // The retire of a store follows right behind it
  `SH4C_ASSERT_NEXT(a_write_then_retire, !out_empty && out_pop && out_kind == KIND_WRITE, !out_empty && out_kind == KIND_RETIRE && out_last)

  // Only a retire carries a next pc
  `SH4C_ASSERT_NOW(a_npc_retire_only, !out_empty && out_kind != KIND_RETIRE, out_next_pc == 32'd0)

endmodule

bind sh4_group_c_instruction_execute_top sh4c_checker u_sh4c_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_empty   (out_empty),
  .out_pop     (out_pop),
  .out_kind    (out_kind),
  .out_addr    (out_addr),
  .out_next_pc (out_next_pc),
  .out_last    (out_last)
);
